@@ rtl/indexed_fifo_queue_engine_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef INDEXED_FIFO_QUEUE_ENGINE_MACROS_SVH
`define INDEXED_FIFO_QUEUE_ENGINE_MACROS_SVH

// Plain clocked assertion, disabled during reset.
`define IFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal keeps its value into the next cycle whenever the condition is high.
`define IFQ_HOLD(lbl, clk, rst_n, cond, sig, msg) \
	`IFQ_ASSERT(lbl, clk, rst_n, (cond) |=> $stable(sig), msg)

`endif

@@ rtl/ifq_pkg.sv @@
package ifq_pkg;

	localparam int POS_W = 10;
	localparam int CMD_W = 4;
	localparam int ST_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ    = 4'd0,
		CMD_DEQ    = 4'd1,
		CMD_PEEK   = 4'd2,
		CMD_LEN    = 4'd3,
		CMD_GET    = 4'd4,
		CMD_REM    = 4'd5,
		CMD_FIND   = 4'd6,
		CMD_CHG    = 4'd7,
		CMD_SORT   = 4'd8,
		CMD_CLR    = 4'd9,
		CMD_SUM    = 4'd10,
		CMD_REV    = 4'd11
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_EQ  = 2'd1,
		ALU_GT  = 2'd2
	} alu_op_t;

endpackage

@@ rtl/ifq_ram.sv @@
module ifq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ifq_alu.sv @@
module ifq_alu #(
	parameter int DATA_WIDTH = 32
) (
	input  ifq_pkg::alu_op_t       op,
	input  logic [DATA_WIDTH-1:0]  a,
	input  logic [DATA_WIDTH-1:0]  b,
	output logic [DATA_WIDTH-1:0]  res,
	output logic                   flag
);

	always_comb begin
		res  = a + b;
		flag = 1'b0;
		unique case (op)
			ifq_pkg::ALU_ADD: flag = 1'b0;
			ifq_pkg::ALU_EQ:  flag = (a == b);
			ifq_pkg::ALU_GT:  flag = ($signed(a) > $signed(b));
			default:          flag = 1'b0;
		endcase
	end

endmodule

@@ rtl/indexed_fifo_queue_engine.sv @@
// Indexed FIFO queue engine.
// Input channel: in_valid/in_stall carry one command item (command, value,
// position). Output channel: out_valid/out_stall return one result item per
// command (data_out, occupancy, status).
// A small sequencer drives one entry RAM (one write, one registered read per
// cycle) and one shared add/compare unit. in_stall is high from acceptance
// until the result is in the output register. Length, clear, enqueue, change
// and the empty or position errors finish from the start state; dequeue, peek
// and get read one entry; find walks all n entries and strided sum every
// (position+1)-th one; remove shifts the entries behind position down;
// reverse swaps entries from both ends; sort is a bubble sort of up to n passes.
// The result register frees the engine: the next item is taken while a result
// waits. If out_stall holds, a finished item waits in the sequencer.
// Reset empties the queue (head and count to zero) and clears out_valid;
// the entry RAM is not cleared and needs no clearing pass.
module indexed_fifo_queue_engine #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ifq_pkg::CMD_W-1:0]            command,
	input  logic signed [DATA_WIDTH-1:0]         value,
	input  logic [ifq_pkg::POS_W-1:0]            position,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [DATA_WIDTH-1:0]         data_out,
	output logic [$clog2(DEPTH+1)-1:0]           occupancy,
	output logic [ifq_pkg::ST_W-1:0]             status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = ((CW > ifq_pkg::POS_W) ? CW : ifq_pkg::POS_W) + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_LOOP,
		S_USE,
		S_REVW,
		S_FIN
	} state_t;

	state_t                   state_q;
	ifq_pkg::cmd_t            cmd_q;
	logic [DATA_WIDTH-1:0]    val_q;
	logic [ifq_pkg::POS_W-1:0] pos_q;
	logic [AW-1:0]            head_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            i_q;
	logic [CW-1:0]            j_q;
	logic [DATA_WIDTH-1:0]    acc_q;
	logic [DATA_WIDTH-1:0]    cur_q;
	logic [DATA_WIDTH-1:0]    res_q;
	ifq_pkg::status_t         st_q;
	logic                     hit_q;
	logic                     swapped_q;
	logic                     phase_q;
	logic                     out_valid_q;
	logic [DATA_WIDTH-1:0]    data_out_q;
	logic [CW-1:0]            occ_q;
	ifq_pkg::status_t         status_q;

	logic [CW-1:0]            rd_idx;
	logic [CW-1:0]            wr_idx;
	logic                     wr_en;
	logic [DATA_WIDTH-1:0]    wr_data;
	logic [DATA_WIDTH-1:0]    rd_data;
	ifq_pkg::alu_op_t         alu_op;
	logic [DATA_WIDTH-1:0]    alu_a;
	logic [DATA_WIDTH-1:0]    alu_res;
	logic                     alu_flag;
	logic                     pos_bad;
	logic [SW-1:0]            sum_next;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] hd,
			input logic [CW-1:0] idx);
		logic [CW:0] s;
		s = (CW+1)'(hd) + (CW+1)'(idx);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	ifq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_of(head_q, wr_idx)),
		.wdata (wr_data),
		.raddr (slot_of(head_q, rd_idx)),
		.rdata (rd_data)
	);

	ifq_alu #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (rd_data),
		.res  (alu_res),
		.flag (alu_flag)
	);

	assign pos_bad  = (SW'(pos_q) >= SW'(cnt_q));
	assign sum_next = SW'(i_q) + SW'(pos_q) + SW'(1);

	always_comb begin
		case (cmd_q)
			ifq_pkg::CMD_FIND: begin
				alu_op = ifq_pkg::ALU_EQ;
				alu_a  = val_q;
			end
			ifq_pkg::CMD_SORT: begin
				alu_op = ifq_pkg::ALU_GT;
				alu_a  = cur_q;
			end
			default: begin
				alu_op = ifq_pkg::ALU_ADD;
				alu_a  = acc_q;
			end
		endcase
	end

	always_comb begin
		rd_idx  = i_q;
		wr_idx  = i_q;
		wr_en   = 1'b0;
		wr_data = val_q;
		case (state_q)
			S_START: begin
				if (cmd_q == ifq_pkg::CMD_ENQ && SW'(cnt_q) < SW'(DEPTH)) begin
					wr_en  = 1'b1;
					wr_idx = cnt_q;
				end else if (cmd_q == ifq_pkg::CMD_CHG && !pos_bad) begin
					wr_en  = 1'b1;
					wr_idx = CW'(pos_q);
				end
			end
			S_LOOP: begin
				if (cmd_q == ifq_pkg::CMD_REM) begin
					rd_idx = i_q + CW'(1);
				end else if (cmd_q == ifq_pkg::CMD_REV && phase_q) begin
					rd_idx = j_q;
				end else if (cmd_q == ifq_pkg::CMD_SORT && i_q == cnt_q) begin
					wr_en   = 1'b1;
					wr_idx  = cnt_q - CW'(1);
					wr_data = cur_q;
				end
			end
			S_USE: begin
				if (cmd_q == ifq_pkg::CMD_REM) begin
					wr_en   = 1'b1;
					wr_data = rd_data;
				end else if (cmd_q == ifq_pkg::CMD_SORT && i_q != '0) begin
					wr_en   = 1'b1;
					wr_idx  = i_q - CW'(1);
					wr_data = alu_flag ? rd_data : cur_q;
				end else if (cmd_q == ifq_pkg::CMD_REV && phase_q) begin
					wr_en   = 1'b1;
					wr_data = rd_data;
				end
			end
			S_REVW: begin
				wr_en   = 1'b1;
				wr_idx  = j_q;
				wr_data = cur_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= ifq_pkg::CMD_LEN;
			val_q       <= '0;
			pos_q       <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			acc_q       <= '0;
			cur_q       <= '0;
			res_q       <= '0;
			st_q        <= ifq_pkg::ST_OK;
			hit_q       <= 1'b0;
			swapped_q   <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			data_out_q  <= '0;
			occ_q       <= '0;
			status_q    <= ifq_pkg::ST_OK;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q     <= ifq_pkg::cmd_t'(command);
						val_q     <= value;
						pos_q     <= position;
						st_q      <= ifq_pkg::ST_OK;
						res_q     <= '0;
						acc_q     <= '0;
						i_q       <= '0;
						hit_q     <= 1'b0;
						swapped_q <= 1'b0;
						phase_q   <= 1'b0;
						state_q   <= S_START;
					end
				end
				S_START: begin
					state_q <= S_FIN;
					case (cmd_q)
						ifq_pkg::CMD_ENQ: begin
							if (SW'(cnt_q) < SW'(DEPTH)) begin
								cnt_q <= cnt_q + CW'(1);
							end else begin
								st_q <= ifq_pkg::ST_FULL;
							end
						end
						ifq_pkg::CMD_DEQ, ifq_pkg::CMD_PEEK: begin
							if (cnt_q == '0) begin
								st_q <= ifq_pkg::ST_EMPTY;
							end else begin
								state_q <= S_LOOP;
							end
						end
						ifq_pkg::CMD_GET, ifq_pkg::CMD_REM: begin
							if (pos_bad) begin
								st_q <= ifq_pkg::ST_NOTFOUND;
							end else begin
								i_q     <= CW'(pos_q);
								state_q <= S_LOOP;
							end
						end
						ifq_pkg::CMD_CHG: begin
							if (pos_bad) begin
								st_q <= ifq_pkg::ST_NOTFOUND;
							end
						end
						ifq_pkg::CMD_FIND, ifq_pkg::CMD_SUM: state_q <= S_LOOP;
						ifq_pkg::CMD_SORT: begin
							if (SW'(cnt_q) >= SW'(2)) begin
								state_q <= S_LOOP;
							end
						end
						ifq_pkg::CMD_CLR: begin
							head_q <= '0;
							cnt_q  <= '0;
						end
						ifq_pkg::CMD_REV: begin
							j_q     <= (cnt_q == '0) ? '0 : cnt_q - CW'(1);
							state_q <= S_LOOP;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_LOOP: begin
					state_q <= S_FIN;
					case (cmd_q)
						ifq_pkg::CMD_DEQ, ifq_pkg::CMD_PEEK, ifq_pkg::CMD_GET:
							state_q <= S_USE;
						ifq_pkg::CMD_REM: begin
							if (SW'(i_q) + SW'(1) < SW'(cnt_q)) begin
								state_q <= S_USE;
							end else begin
								cnt_q <= cnt_q - CW'(1);
							end
						end
						ifq_pkg::CMD_FIND: begin
							if (i_q < cnt_q) begin
								state_q <= S_USE;
							end else if (!hit_q) begin
								st_q  <= ifq_pkg::ST_NOTFOUND;
								res_q <= '0;
							end
						end
						ifq_pkg::CMD_SUM: begin
							if (i_q < cnt_q) begin
								state_q <= S_USE;
							end else begin
								res_q <= acc_q;
							end
						end
						ifq_pkg::CMD_SORT: begin
							if (i_q < cnt_q) begin
								state_q <= S_USE;
							end else if (swapped_q) begin
								i_q       <= '0;
								swapped_q <= 1'b0;
								state_q   <= S_LOOP;
							end
						end
						ifq_pkg::CMD_REV: begin
							if (i_q < j_q) begin
								state_q <= S_USE;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_USE: begin
					state_q <= S_LOOP;
					case (cmd_q)
						ifq_pkg::CMD_DEQ, ifq_pkg::CMD_PEEK, ifq_pkg::CMD_GET: begin
							res_q   <= rd_data;
							state_q <= S_FIN;
							if (cmd_q == ifq_pkg::CMD_DEQ) begin
								head_q <= (SW'(head_q) == SW'(DEPTH - 1)) ? '0
									: head_q + AW'(1);
								cnt_q  <= cnt_q - CW'(1);
							end
						end
						ifq_pkg::CMD_REM: i_q <= i_q + CW'(1);
						ifq_pkg::CMD_FIND: begin
							if (alu_flag) begin
								hit_q <= 1'b1;
								res_q <= DATA_WIDTH'(i_q);
							end
							i_q <= i_q + CW'(1);
						end
						ifq_pkg::CMD_SUM: begin
							acc_q <= alu_res;
							i_q   <= (sum_next >= SW'(cnt_q)) ? cnt_q : CW'(sum_next);
						end
						ifq_pkg::CMD_SORT: begin
							if (i_q == '0 || !alu_flag) begin
								cur_q <= rd_data;
							end else begin
								swapped_q <= 1'b1;
							end
							i_q <= i_q + CW'(1);
						end
						ifq_pkg::CMD_REV: begin
							if (!phase_q) begin
								cur_q   <= rd_data;
								phase_q <= 1'b1;
							end else begin
								state_q <= S_REVW;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_REVW: begin
					i_q     <= i_q + CW'(1);
					j_q     <= j_q - CW'(1);
					phase_q <= 1'b0;
					state_q <= S_LOOP;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						data_out_q  <= res_q;
						occ_q       <= cnt_q;
						status_q    <= st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign occupancy = occ_q;
	assign status    = status_q;

endmodule

@@ rtl/ifq_checker.sv @@
`include "indexed_fifo_queue_engine_macros.svh"

module ifq_assert_checker #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [DATA_WIDTH-1:0]         data_out,
	input logic [$clog2(DEPTH+1)-1:0]    occupancy,
	input logic [ifq_pkg::ST_W-1:0]      status
);

	`IFQ_ASSERT(a_occ_range, clk, arst_n,
		out_valid |-> (32'(occupancy) <= 32'(DEPTH)), "occupancy above depth")
	`IFQ_ASSERT(a_full_occ, clk, arst_n,
		(out_valid && status == ifq_pkg::ST_FULL) |-> (32'(occupancy) == 32'(DEPTH)),
		"full status with room left")
	`IFQ_ASSERT(a_empty_occ, clk, arst_n,
		(out_valid && status == ifq_pkg::ST_EMPTY) |-> (occupancy == '0 && data_out == '0),
		"empty status with entries or data")
	`IFQ_HOLD(a_out_hold, clk, arst_n, out_valid && out_stall, data_out,
		"stalled item changed")
	`IFQ_ASSERT(a_busy_after_accept, clk, arst_n,
		(in_valid && !in_stall) |=> in_stall, "input not stalled after accept")

endmodule

bind indexed_fifo_queue_engine ifq_assert_checker #(
	.DEPTH      (DEPTH),
	.DATA_WIDTH (DATA_WIDTH)
) u_ifq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.data_out  (data_out),
	.occupancy (occupancy),
	.status    (status)
);
